// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rcs_pkg.sv =====
// ----------------------------------------------------------------------------
// rcs_pkg
// Constants, rotor alphabets and lookup functions of the rotor cipher.
// ----------------------------------------------------------------------------
package rcs_pkg;

    localparam int ALPHA_SIZE        = 63;
    localparam int CARRY_PERIOD      = 27;
    localparam int QUEUE_DEPTH_DEF   = 2;

    localparam int PW = $clog2(ALPHA_SIZE + 1);   // position, with one code for absent
    localparam int CW = $clog2(CARRY_PERIOD);     // step count

    typedef logic [8*ALPHA_SIZE-1:0] t_rom;
    typedef logic [PW-1:0]           t_pos;
    typedef logic [CW-1:0]           t_cnt;

    // first character sits in the top byte
    localparam t_rom ROM_SMALL  =
        " EJOTYCHMReVFKPUZDINSXBGLQAWjotychmrwafkpuzdinsxbglqv0123456789";
    localparam t_rom ROM_MEDIUM =
        "2 5EJOTYLH6MRWAFGPUZDINSXBKCQV9ejot83ych0mrwafk7puzdi4nsxbglqv1";
    localparam t_rom ROM_LARGE  =
        "01 B2bdfh34ACEG5cegi6UWYjlJH789DFpnLNPRTVXZIKMOQSrtvxzakmoqsuwy";

    localparam t_pos POS_ABSENT = t_pos'(ALPHA_SIZE);

    // one queued transaction, classified by the front end
    typedef struct packed {
        logic        mode;
        logic [7:0]  ch;
        logic        start;
        t_pos        pos_small;
        logic        in_alpha;
    } t_entry;

    function automatic logic [7:0] rom_sym(input t_rom rom, input t_pos idx);
        return rom[8*(ALPHA_SIZE-1-int'(idx)) +: 8];
    endfunction

    // inverse table: position of a code in a base alphabet, or absent
    function automatic t_pos rom_pos(input t_rom rom, input logic [7:0] c);
        t_pos pos;
        logic hit;
        pos = POS_ABSENT;
        hit = 1'b0;
        for (int k = 0; k < ALPHA_SIZE; k++) begin
            if (!hit && rom[8*(ALPHA_SIZE-1-k) +: 8] == c) begin
                pos = t_pos'(k);
                hit = 1'b1;
            end
        end
        return pos;
    endfunction

    function automatic t_pos add_mod(input t_pos a, input t_pos b);
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PW+1)'(ALPHA_SIZE)) begin
            s = s - (PW+1)'(ALPHA_SIZE);
        end
        return s[PW-1:0];
    endfunction

    function automatic t_pos sub_mod(input t_pos a, input t_pos b);
        logic [PW:0] s;
        if (a >= b) begin
            s = {1'b0, a} - {1'b0, b};
        end else begin
            s = {1'b0, a} + ((PW+1)'(ALPHA_SIZE) - {1'b0, b});
        end
        return s[PW-1:0];
    endfunction

endpackage

// ===== rtl/rcs_front.sv =====
// ----------------------------------------------------------------------------
// rcs_front
// Accepts characters and classifies them against the small rotor alphabet.
// ----------------------------------------------------------------------------
module rcs_front import rcs_pkg::*; (
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_mode,
    input  logic [7:0] i_char_in,
    input  logic       i_message_start,
    input  logic       i_q_full,
    output logic       o_push,
    output t_entry     o_entry
);

    t_pos pos_small;

    assign pos_small = rom_pos(ROM_SMALL, i_char_in);

    // nothing is taken while reset is held
    assign o_ready = i_rst_n && !i_q_full;
    assign o_push  = i_valid && o_ready;

    assign o_entry.mode      = i_mode;
    assign o_entry.ch        = i_char_in;
    assign o_entry.start     = i_message_start;
    assign o_entry.pos_small = pos_small;
    assign o_entry.in_alpha  = (pos_small != POS_ABSENT);

endmodule

// ===== rtl/rcs_queue.sv =====
// ----------------------------------------------------------------------------
// rcs_queue
// Small register queue between the front end and the rotor datapath.
// ----------------------------------------------------------------------------
module rcs_queue import rcs_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [NW-1:0] r_count,  n_count;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== rtl/rcs_back.sv =====
// ----------------------------------------------------------------------------
// rcs_back
// Rotor datapath: runs the substitution chain, steps the rotors and holds
// the output register.
// ----------------------------------------------------------------------------
module rcs_back import rcs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_entry     i_entry,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_char_out,
    output logic       o_passed_through
);

    t_pos r_small_off, n_small_off;
    t_cnt r_small_cnt, n_small_cnt;
    t_pos r_medium_off, n_medium_off;
    t_cnt r_medium_cnt, n_medium_cnt;
    t_pos r_large_off, n_large_off;

    logic       r_valid;
    logic [7:0] r_char_out, n_char_out;
    logic       r_passed,   n_passed;

    // offsets seen by this character, cleared at a message start
    t_pos so, mo, lo;
    t_cnt sc, mc;
    t_pos idx_i, idx_j, pos_m;
    logic [7:0] sym_m;
    logic ok;

    assign o_pop = i_q_valid && (!r_valid || i_ready);

    always_comb begin
        so = i_entry.start ? '0 : r_small_off;
        sc = i_entry.start ? '0 : r_small_cnt;
        mo = i_entry.start ? '0 : r_medium_off;
        mc = i_entry.start ? '0 : r_medium_cnt;
        lo = i_entry.start ? '0 : r_large_off;

        idx_i = sub_mod(i_entry.pos_small, so);
        if (i_entry.mode) begin
            sym_m = rom_sym(ROM_LARGE, add_mod(idx_i, lo));
            pos_m = rom_pos(ROM_MEDIUM, sym_m);
            idx_j = sub_mod(pos_m, mo);
        end else begin
            sym_m = rom_sym(ROM_MEDIUM, add_mod(idx_i, mo));
            pos_m = rom_pos(ROM_LARGE, sym_m);
            idx_j = sub_mod(pos_m, lo);
        end
        ok = i_entry.in_alpha && (pos_m != POS_ABSENT);

        n_small_off  = so;
        n_small_cnt  = sc;
        n_medium_off = mo;
        n_medium_cnt = mc;
        n_large_off  = lo;
        if (ok) begin
            n_char_out  = rom_sym(ROM_SMALL, add_mod(idx_j, so));
            n_passed    = 1'b0;
            n_small_off = add_mod(so, t_pos'(1));
            if (sc == t_cnt'(CARRY_PERIOD - 1)) begin
                n_small_cnt  = '0;
                n_medium_off = add_mod(mo, t_pos'(1));
                if (mc == t_cnt'(CARRY_PERIOD - 1)) begin
                    n_medium_cnt = '0;
                    n_large_off  = add_mod(lo, t_pos'(1));
                end else begin
                    n_medium_cnt = mc + 1'b1;
                end
            end else begin
                n_small_cnt = sc + 1'b1;
            end
        end else begin
            n_char_out = i_entry.ch;
            n_passed   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_small_off  <= '0;
            r_small_cnt  <= '0;
            r_medium_off <= '0;
            r_medium_cnt <= '0;
            r_large_off  <= '0;
        end else begin
            if (o_pop) begin
                r_valid      <= 1'b1;
                r_small_off  <= n_small_off;
                r_small_cnt  <= n_small_cnt;
                r_medium_off <= n_medium_off;
                r_medium_cnt <= n_medium_cnt;
                r_large_off  <= n_large_off;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_char_out <= n_char_out;
            r_passed   <= n_passed;
        end
    end

    assign o_valid          = r_valid;
    assign o_char_out       = r_char_out;
    assign o_passed_through = r_passed;

endmodule

// ===== rtl/three_rotor_substitution_cipher.sv =====
// ----------------------------------------------------------------------------
// three_rotor_substitution_cipher
// Three-rotor character cipher with a decoupled front end and rotor datapath.
// ----------------------------------------------------------------------------
// Takes one character per cycle while the queue has room and returns one
// result per character, in order. An accepted character is written into the
// queue and then into the output register; the rotor chain (three alphabet
// lookups with modular offset adds) and the rotor stepping are combinational
// between the two, so the back end retires one character per cycle while its
// output register is empty or being read. A queue of QUEUE_DEPTH entries sits
// between the classifying front end and the datapath, and lets new characters
// be taken while a result still waits in the output register. Characters outside
// the 63-symbol alphabet come back unchanged with passed_through set and do not
// step the rotors; message_start clears all rotor offsets and step counts before its character is handled.
module three_rotor_substitution_cipher import rcs_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_mode,
    input  logic [7:0] i_char_in,
    input  logic       i_message_start,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_char_out,
    output logic       o_passed_through
);

    t_entry front_entry, q_entry;
    logic   push, pop, q_full, q_valid;

    rcs_front u_front (
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_char_in       (i_char_in),
        .i_message_start (i_message_start),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_entry         (front_entry)
    );

    rcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    rcs_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_entry          (q_entry),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_char_out       (o_char_out),
        .o_passed_through (o_passed_through)
    );

endmodule

// ===== rtl/rcs_checker.sv =====
// ----------------------------------------------------------------------------
// rcs_checker
// Port-level checks of the rotor cipher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rcs_checker import rcs_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_char_out,
    input logic       o_passed_through
);

    localparam int MAX_OUT = QUEUE_DEPTH + 1;
    localparam int KW      = $clog2(MAX_OUT + 2);

    logic          in_acc, out_acc;
    logic [KW-1:0] r_outstanding;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    // transactions taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else if (in_acc && !out_acc) begin
            r_outstanding <= r_outstanding + 1'b1;
        end else if (!in_acc && out_acc) begin
            r_outstanding <= r_outstanding - 1'b1;
        end
    end

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_char_out) && $stable(o_passed_through), "result changed while stalled")
    `ASSERT_CLK_NR(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "result shown after reset")
    `ASSERT_CLK(a_no_invented, i_clk, i_rst_n, o_valid |-> r_outstanding != '0, "result without a transaction")
    `ASSERT_CLK(a_bounded, i_clk, i_rst_n, r_outstanding <= KW'(MAX_OUT), "more transactions held than storage")

endmodule

bind three_rotor_substitution_cipher rcs_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_rcs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_char_out       (o_char_out),
    .o_passed_through (o_passed_through)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-rotor substitution cipher. A queue of
// characters (a directed opening, then random messages with noise) feeds a
// valid/ready driver. A predictor of the rotor chain and its stepping, kept
// alongside the block, gives the expected character for every accepted
// transaction, and the monitor checks each result in order. Random gaps and
// stalls are applied on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import rcs_pkg::*;

    localparam int          CLK_PERIOD   = 4;
    localparam int          RESET_CYCLES = 9;
    localparam int          RANDOM_ITEMS = 1850;
    localparam int          DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int          REPORT_MAX   = 10;

    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    typedef logic [8*ALPHA_SIZE-1:0] t_rotor_alpha;

    // first symbol in the top byte
    localparam t_rotor_alpha ALPHA_SMALL  =
        " EJOTYCHMReVFKPUZDINSXBGLQAWjotychmrwafkpuzdinsxbglqv0123456789";
    localparam t_rotor_alpha ALPHA_MEDIUM =
        "2 5EJOTYLH6MRWAFGPUZDINSXBKCQV9ejot83ych0mrwafk7puzdi4nsxbglqv1";
    localparam t_rotor_alpha ALPHA_LARGE  =
        "01 B2bdfh34ACEG5cegi6UWYjlJH789DFpnLNPRTVXZIKMOQSrtvxzakmoqsuwy";

    typedef struct {
        logic        mode;
        logic [7:0]  ch;
        logic        start;
        int unsigned gap;
        bit          drain;
    } t_char_item;

    typedef struct packed {
        logic [7:0] char_out;
        logic       passed;
    } t_cipher_result;

    logic       i_clk            = 1'b0;
    logic       i_rst_n          = 1'b0;
    logic       i_valid          = 1'b0;
    logic       i_mode           = MODE_ENCRYPT;
    logic [7:0] i_char_in        = 8'h00;
    logic       i_message_start  = 1'b0;
    logic       i_ready          = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_char_out;
    logic       o_passed_through;

    t_char_item     char_items[$];
    t_cipher_result expected_chars[$];

    // predictor state
    logic [5:0] small_off;
    logic [4:0] small_cnt;
    logic [5:0] med_off;
    logic [4:0] med_cnt;
    logic [5:0] large_off;

    int          item_total     = 0;
    int          accepted_count = 0;
    int unsigned cycle_count    = 0;
    int          fail_count     = 0;
    int          n_enc          = 0;
    int          n_dec          = 0;
    int          n_pass         = 0;
    int          n_messages     = 0;
    int          n_medium_steps = 0;
    int          n_large_steps  = 0;

    bit          tx_taken     = 1'b0;
    bit          tx_loaded    = 1'b0;
    t_char_item  tx_cur;
    int unsigned tx_idle_left = 0;
    int unsigned rx_stall_left = 0;
    int unsigned rx_quiet_left = 0;

    three_rotor_substitution_cipher uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_char_in        (i_char_in),
        .i_message_start  (i_message_start),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_char_out       (o_char_out),
        .o_passed_through (o_passed_through)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [7:0] alpha_symbol(input t_rotor_alpha alpha, input int idx);
        return alpha[8*(ALPHA_SIZE-1-idx) +: 8];
    endfunction

    // position in the unrotated alphabet, ALPHA_SIZE when absent
    function automatic int alpha_index(input t_rotor_alpha alpha, input logic [7:0] c);
        for (int k = 0; k < ALPHA_SIZE; k++) begin
            if (alpha[8*(ALPHA_SIZE-1-k) +: 8] == c) begin
                return k;
            end
        end
        return ALPHA_SIZE;
    endfunction

    // mostly short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(13, 60);
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
            $display("%s", msg);
        end
    endfunction

    task automatic add_char(input logic mode, input logic [7:0] ch, input logic start,
                            input int unsigned gap, input bit drain);
        t_char_item it;
        it.mode  = mode;
        it.ch    = ch;
        it.start = start;
        it.gap   = gap;
        it.drain = drain;
        char_items.push_back(it);
    endtask

    // works out the result of one character and advances the rotors
    task automatic rotor_cipher_char(input logic mode, input logic [7:0] ch,
                                     input logic start);
        t_cipher_result res;
        int             pos_small;
        int             pos_in;
        int             pos_mid;
        int             pos_out;
        logic [7:0]     mid;
        if (start) begin
            small_off = '0;
            small_cnt = '0;
            med_off   = '0;
            med_cnt   = '0;
            large_off = '0;
            n_messages++;
        end
        res.char_out = ch;
        res.passed   = 1'b1;
        pos_mid      = ALPHA_SIZE;
        pos_out      = 0;
        pos_small    = alpha_index(ALPHA_SMALL, ch);
        if (pos_small < ALPHA_SIZE) begin
            pos_in = (pos_small + ALPHA_SIZE - int'(small_off)) % ALPHA_SIZE;
            if (mode == MODE_ENCRYPT) begin
                mid     = alpha_symbol(ALPHA_MEDIUM, (pos_in + int'(med_off)) % ALPHA_SIZE);
                pos_mid = alpha_index(ALPHA_LARGE, mid);
                pos_out = (pos_mid + ALPHA_SIZE - int'(large_off)) % ALPHA_SIZE;
            end else begin
                mid     = alpha_symbol(ALPHA_LARGE, (pos_in + int'(large_off)) % ALPHA_SIZE);
                pos_mid = alpha_index(ALPHA_MEDIUM, mid);
                pos_out = (pos_mid + ALPHA_SIZE - int'(med_off)) % ALPHA_SIZE;
            end
        end
        if (pos_mid < ALPHA_SIZE) begin
            res.char_out = alpha_symbol(ALPHA_SMALL, (pos_out + int'(small_off)) % ALPHA_SIZE);
            res.passed   = 1'b0;
            if (mode == MODE_ENCRYPT) begin
                n_enc++;
            end else begin
                n_dec++;
            end
            small_off = 6'((int'(small_off) + 1) % ALPHA_SIZE);
            small_cnt = 5'((int'(small_cnt) + 1) % CARRY_PERIOD);
            if (small_cnt == 0) begin
                med_off = 6'((int'(med_off) + 1) % ALPHA_SIZE);
                med_cnt = 5'((int'(med_cnt) + 1) % CARRY_PERIOD);
                n_medium_steps++;
                if (med_cnt == 0) begin
                    large_off = 6'((int'(large_off) + 1) % ALPHA_SIZE);
                    n_large_steps++;
                end
            end
        end else begin
            n_pass++;
        end
        expected_chars.push_back(res);
    endtask

    // output check first, then capture of the input transaction
    always @(posedge i_clk) begin : monitor
        t_cipher_result want;
        cycle_count++;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_chars.size() == 0) begin
                note_failure($sformatf("unexpected result: char_out %02h passed_through %0b",
                                       o_char_out, o_passed_through));
            end else begin
                want = expected_chars.pop_front();
                if (o_char_out !== want.char_out || o_passed_through !== want.passed) begin
                    note_failure($sformatf(
                        "mismatch: char_out %02h (expected %02h), %s %0b (expected %0b)",
                        o_char_out, want.char_out, "passed_through", o_passed_through,
                        want.passed));
                end
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            rotor_cipher_char(i_mode, i_char_in, i_message_start);
            accepted_count++;
            tx_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin : tx_driver
        logic launch;
        launch = 1'b0;
        if (i_rst_n && (tx_taken || !i_valid)) begin
            if (tx_taken) begin
                tx_taken  = 1'b0;
                tx_loaded = 1'b0;
            end
            if (!tx_loaded && char_items.size() != 0) begin
                tx_cur       = char_items.pop_front();
                tx_loaded    = 1'b1;
                tx_idle_left = tx_cur.gap;
            end
            if (tx_loaded) begin
                if (tx_idle_left != 0) begin
                    tx_idle_left--;
                end else if (!(tx_cur.drain && expected_chars.size() != 0)) begin
                    // a drain item holds off until every result is back
                    launch = 1'b1;
                end
            end
            i_valid <= launch;
            if (launch) begin
                i_mode          <= tx_cur.mode;
                i_char_in       <= tx_cur.ch;
                i_message_start <= tx_cur.start;
            end
        end
    end

    always @(negedge i_clk) begin : rx_driver
        if (rx_quiet_left != 0) begin
            rx_quiet_left--;
            i_ready <= 1'b1;
        end else if (rx_stall_left != 0) begin
            rx_stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 299) == 0) begin
                rx_quiet_left = $urandom_range(50, 250);
            end else if ($urandom_range(0, 2) == 0) begin
                rx_stall_left = pick_gap();
            end
        end
    end

    initial begin : stimulus
        int          made;
        int          msg_len;
        int          k;
        int unsigned quiet_left;
        int unsigned gap;
        bit          first_msg;
        bit          long_msg;
        logic        msg_mode;
        logic        mode;
        logic [7:0]  ch;
        logic        start;

        // directed opening: alphabet ends, out-of-alphabet codes, both modes
        add_char(MODE_ENCRYPT, " ",   1'b1, 0, 1'b0);
        add_char(MODE_ENCRYPT, "9",   1'b0, 0, 1'b0);
        add_char(MODE_ENCRYPT, "A",   1'b0, 0, 1'b0);
        add_char(MODE_ENCRYPT, 8'h00, 1'b0, 0, 1'b0);
        add_char(MODE_ENCRYPT, 8'hFF, 1'b0, 1, 1'b0);
        add_char(MODE_ENCRYPT, 8'h80, 1'b0, 0, 1'b0);
        add_char(MODE_ENCRYPT, 8'h7F, 1'b0, 0, 1'b0);
        add_char(MODE_ENCRYPT, "z",   1'b0, 0, 1'b0);
        add_char(MODE_DECRYPT, "z",   1'b1, 2, 1'b0);
        add_char(MODE_DECRYPT, "e",   1'b0, 0, 1'b0);
        add_char(MODE_DECRYPT, 8'h0A, 1'b0, 0, 1'b0);
        add_char(MODE_DECRYPT, "9",   1'b0, 0, 1'b0);
        add_char(MODE_DECRYPT, " ",   1'b0, 0, 1'b0);
        // start on a pass-through character still clears the rotors
        add_char(MODE_ENCRYPT, "!",   1'b1, 0, 1'b0);
        add_char(MODE_ENCRYPT, " ",   1'b0, 0, 1'b0);
        add_char(MODE_ENCRYPT, "0",   1'b0, 0, 1'b0);
        add_char(MODE_DECRYPT, "Z",   1'b1, 0, 1'b1);
        add_char(MODE_DECRYPT, "a",   1'b0, 0, 1'b0);
        add_char(MODE_ENCRYPT, "q",   1'b0, 0, 1'b0);
        add_char(MODE_DECRYPT, 8'hC3, 1'b1, 0, 1'b0);
        add_char(MODE_ENCRYPT, "W",   1'b0, 3, 1'b1);

        // random messages, the first long enough to carry into the large rotor
        made       = 0;
        quiet_left = 0;
        first_msg  = 1'b1;
        while (made < RANDOM_ITEMS) begin
            msg_len   = first_msg ? $urandom_range(760, 800) : $urandom_range(1, 60);
            long_msg  = first_msg;
            first_msg = 1'b0;
            msg_mode  = 1'($urandom_range(0, 1));
            for (k = 0; k < msg_len; k++) begin
                mode = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : msg_mode;
                // the long message keeps to the alphabet so every character steps
                if (long_msg || $urandom_range(0, 99) < 85) begin
                    ch = alpha_symbol(ALPHA_SMALL, $urandom_range(0, ALPHA_SIZE - 1));
                end else begin
                    ch = 8'($urandom_range(0, 255));
                end
                // a few messages carry on from the previous state, a few restart midway
                if (k == 0) begin
                    start = ($urandom_range(0, 9) != 0);
                end else begin
                    start = !long_msg && ($urandom_range(0, 99) == 0);
                end
                if (quiet_left != 0) begin
                    quiet_left--;
                    gap = 0;
                end else if ($urandom_range(0, 149) == 0) begin
                    quiet_left = $urandom_range(40, 200);
                    gap        = 0;
                end else begin
                    gap = pick_gap();
                end
                add_char(mode, ch, start, gap, $urandom_range(0, 199) == 0);
                made++;
            end
        end
        item_total = char_items.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count != item_total) @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d characters in %0d messages", accepted_count, n_messages);
        $display("%0d enciphered, %0d deciphered, %0d passed through",
                 n_enc, n_dec, n_pass);
        $display("rotor carries: %0d medium steps, %0d large steps; %0d failures",
                 n_medium_steps, n_large_steps, fail_count);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_chars.size());
        $display("status: fail");
        $finish;
    end

endmodule
